// ----- rtl/expression_lexer_macros.svh -----
// Assertion macros for the expression lexer.
// Used by the top level; each macro expects signals clk and rst in scope.
`ifndef EXPRESSION_LEXER_MACROS_SVH
`define EXPRESSION_LEXER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/exlex_pkg.sv -----
// Package for the expression lexer: result item type, token and error codes,
// character constants and token classification helpers. No dependencies.
package exlex_pkg;

  // Default sizes.
  localparam int MAX_TOKEN_LEN_DEF = 64;
  localparam int MAX_LINE_LEN_DEF  = 256;

  // Depth of the result queue; a character can push two items.
  localparam int QUEUE_DEPTH = 4;

  // Saturation value of integer tokens.
  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  // Token kinds.
  localparam logic [3:0] KIND_ADD    = 4'd0;
  localparam logic [3:0] KIND_SUB    = 4'd1;
  localparam logic [3:0] KIND_MUL    = 4'd2;
  localparam logic [3:0] KIND_DIV    = 4'd3;
  localparam logic [3:0] KIND_ASSIGN = 4'd4;
  localparam logic [3:0] KIND_INT    = 4'd5;
  localparam logic [3:0] KIND_NAME   = 4'd6;
  localparam logic [3:0] KIND_OPEN   = 4'd7;
  localparam logic [3:0] KIND_CLOSE  = 4'd8;
  localparam logic [3:0] KIND_LINE   = 4'd9;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_TOKEN   = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [30:0] value;
    logic [7:0]  start;
    logic [6:0]  len;
    logic [1:0]  err;
    logic        last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_EQUAL);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic result_t make_res(input logic [3:0] kind, input logic [30:0] value,
                                       input logic [7:0] start, input logic [6:0] len,
                                       input logic [1:0] err, input logic last);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.start = start;
    r.len   = len;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

  // Classify a closed token into an operator, integer, name or error item.
  function automatic result_t close_token(input logic [6:0] len, input logic [7:0] first,
                                          input logic digits, input logic alnum,
                                          input logic [30:0] acc, input logic [7:0] start,
                                          input logic last);
    result_t r;
    logic [3:0] op_kind;
    case (first)
      CH_PLUS:  op_kind = KIND_ADD;
      CH_MINUS: op_kind = KIND_SUB;
      CH_STAR:  op_kind = KIND_MUL;
      CH_SLASH: op_kind = KIND_DIV;
      default:  op_kind = KIND_ASSIGN;
    endcase
    if ((len == 7'd1) && is_oper(first)) begin
      r = make_res(op_kind, 31'd0, start, len, ERR_NONE, last);
    end else if (digits) begin
      r = make_res(KIND_INT, acc, start, len, ERR_NONE, last);
    end else if (alnum) begin
      r = make_res(KIND_NAME, 31'd0, start, len, ERR_NONE, last);
    end else begin
      r = make_res(KIND_LINE, 31'd0, start, len, ERR_TOKEN, last);
    end
    return r;
  endfunction

endpackage

// ----- rtl/expression_lexer.sv -----
// Expression lexer: one character per cycle in unless stalled, token items out.
// A result item enters the result queue the cycle after its character is accepted.
// One character per cycle while the input is not stalled; a character that closes a token before
// a parenthesis yields two items, drained from a four-entry result queue.
// The input stalls while the queue holds more than two items.
// Reset (synchronous): line state returns to its start values, queue empties.
`include "expression_lexer_macros.svh"

module expression_lexer #(
  parameter int MAX_TOKEN_LEN = exlex_pkg::MAX_TOKEN_LEN_DEF,
  parameter int MAX_LINE_LEN  = exlex_pkg::MAX_LINE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        line_end,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [30:0] int_value,
  output logic [7:0]  start_pos,
  output logic [6:0]  token_len,
  output logic [1:0]  error_code,
  output logic        line_last
);
  import exlex_pkg::*;

  localparam logic [6:0] MaxTok  = 7'(MAX_TOKEN_LEN);
  localparam logic [7:0] LastPos = 8'(MAX_LINE_LEN - 1);
  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);

  // Line state.
  logic [6:0]  pending_len, pending_len_next;
  logic [7:0]  pending_start, pending_start_next;
  logic [7:0]  char_pos, char_pos_next;
  logic        all_digits, all_digits_next;
  logic        all_alnum, all_alnum_next;
  logic [7:0]  first_char, first_char_next;
  logic [30:0] value_acc, value_acc_next;
  logic        skip_line, skip_line_next;

  // Result queue.
  result_t              queue [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr, rd_ptr;
  logic [FillW-1:0]     fill;

  logic    char_accept, token_accept;
  result_t res0, res1;
  logic [1:0] push_n;

  // Intermediate values for a token character.
  logic        c_digit, c_alpha, c_oper, c_space, c_paren;
  logic        start_new, bad;
  logic [7:0]  start_u, first_u;
  logic [30:0] acc_base, acc_u;
  logic        digits_u, alnum_u;
  logic [6:0]  len_u;
  logic [34:0] acc_mul;

  assign char_stall   = fill > FillW'(QUEUE_DEPTH - 2);
  assign char_accept  = char_valid && !char_stall;
  assign token_valid  = fill != '0;
  assign token_accept = token_valid && !token_stall;

  // Character classes.
  assign c_digit = is_digit(char_code);
  assign c_alpha = is_alpha(char_code);
  assign c_oper  = is_oper(char_code);
  assign c_space = is_space(char_code);
  assign c_paren = (char_code == CH_OPEN) || (char_code == CH_CLOSE);

  // Pending token as extended by a token character.
  assign start_new = pending_len == 7'd0;
  assign start_u   = start_new ? char_pos : pending_start;
  assign first_u   = start_new ? char_code : first_char;
  assign acc_base  = start_new ? 31'd0 : value_acc;
  assign len_u     = pending_len + 7'd1;
  assign acc_mul   = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) +
                     35'(char_code[3:0]);
  assign acc_u     = !c_digit ? acc_base :
                     (acc_mul > 35'(INT_SAT)) ? INT_SAT : acc_mul[30:0];
  assign digits_u  = (start_new || all_digits) && c_digit;
  assign alnum_u   = (start_new || all_alnum) && (c_digit || c_alpha);

  // Per-character decision: result items and next line state.
  always_comb begin
    result_t paren_res;
    paren_res = make_res((char_code == CH_OPEN) ? KIND_OPEN : KIND_CLOSE, 31'd0,
                         char_pos, 7'd1, ERR_NONE, line_end);
    res0   = make_res(KIND_LINE, 31'd0, char_pos, 7'd0, ERR_NONE, 1'b1);
    res1   = paren_res;
    push_n = 2'd0;
    bad    = 1'b0;
    pending_len_next   = pending_len;
    pending_start_next = pending_start;
    char_pos_next      = char_pos;
    all_digits_next    = all_digits;
    all_alnum_next     = all_alnum;
    first_char_next    = first_char;
    value_acc_next     = value_acc;
    skip_line_next     = skip_line;

    if (skip_line) begin
      if (line_end) begin
        push_n = 2'd1;
      end
    end else if (c_space) begin
      if (!start_new) begin
        res0 = close_token(pending_len, first_char, all_digits, all_alnum, value_acc,
                           pending_start, line_end);
        bad = res0.err != ERR_NONE;
        push_n = 2'd1;
        pending_len_next = 7'd0;
      end else if (line_end) begin
        push_n = 2'd1;
      end
    end else if (c_paren) begin
      if (!start_new) begin
        res0 = close_token(pending_len, first_char, all_digits, all_alnum, value_acc,
                           pending_start, line_end);
        bad = res0.err != ERR_NONE;
        pending_len_next = 7'd0;
        push_n = bad ? 2'd1 : 2'd2;
      end else begin
        res0 = paren_res;
        push_n = 2'd1;
      end
    end else if (c_digit || c_alpha || c_oper) begin
      if (pending_len >= MaxTok) begin
        res0 = make_res(KIND_LINE, 31'd0, pending_start, MaxTok, ERR_TOO_LONG, line_end);
        push_n = 2'd1;
        bad = 1'b1;
      end else begin
        pending_len_next   = len_u;
        pending_start_next = start_u;
        first_char_next    = first_u;
        all_digits_next    = digits_u;
        all_alnum_next     = alnum_u;
        value_acc_next     = acc_u;
        if (line_end) begin
          res0 = close_token(len_u, first_u, digits_u, alnum_u, acc_u, start_u, 1'b1);
          push_n = 2'd1;
        end
      end
    end else begin
      res0 = make_res(KIND_LINE, 31'd0, char_pos, 7'd1, ERR_CHAR, line_end);
      push_n = 2'd1;
      bad = 1'b1;
    end

    // End of line restores the start values; an error skips the rest.
    if (line_end) begin
      pending_len_next   = 7'd0;
      pending_start_next = 8'd0;
      char_pos_next      = 8'd0;
      all_digits_next    = 1'b1;
      all_alnum_next     = 1'b1;
      first_char_next    = 8'd0;
      value_acc_next     = 31'd0;
      skip_line_next     = 1'b0;
    end else begin
      if (bad) begin
        skip_line_next   = 1'b1;
        pending_len_next = 7'd0;
      end
      if (char_pos < LastPos) begin
        char_pos_next = char_pos + 8'd1;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_len   <= 7'd0;
      pending_start <= 8'd0;
      char_pos      <= 8'd0;
      all_digits    <= 1'b1;
      all_alnum     <= 1'b1;
      first_char    <= 8'd0;
      value_acc     <= 31'd0;
      skip_line     <= 1'b0;
    end else if (char_accept) begin
      pending_len   <= pending_len_next;
      pending_start <= pending_start_next;
      char_pos      <= char_pos_next;
      all_digits    <= all_digits_next;
      all_alnum     <= all_alnum_next;
      first_char    <= first_char_next;
      value_acc     <= value_acc_next;
      skip_line     <= skip_line_next;
    end
  end

  // Queue storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (char_accept && (push_n != 2'd0)) begin
      queue[wr_ptr] <= res0;
      if (push_n == 2'd2) begin
        queue[wr_ptr + PtrW'(1)] <= res1;
      end
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (char_accept) begin
        wr_ptr <= wr_ptr + PtrW'(push_n);
      end
      if (token_accept) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      fill <= fill + (char_accept ? FillW'(push_n) : FillW'(0)) -
              (token_accept ? FillW'(1) : FillW'(0));
    end
  end

  // Head of the queue drives the result item.
  assign token_kind = queue[rd_ptr].kind;
  assign int_value  = queue[rd_ptr].value;
  assign start_pos  = queue[rd_ptr].start;
  assign token_len  = queue[rd_ptr].len;
  assign error_code = queue[rd_ptr].err;
  assign line_last  = queue[rd_ptr].last;

  // Checks on queue bookkeeping and line handling.
  `EL_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FillW'(QUEUE_DEPTH), "queue overfilled")
  `EL_ASSERT_NOW(a_skip_silent, char_accept && skip_line && !line_end, push_n == 2'd0, "item while skipping")
  `EL_ASSERT_NOW(a_line_result, char_accept && line_end, push_n != 2'd0, "line end without item")
  `EL_ASSERT_NEXT(a_line_clear, char_accept && line_end, (char_pos == 8'd0) && !skip_line, "line state kept")

endmodule
